FILE: rtl/trcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trcc_pkg;

    // coordinate and datapath widths
    localparam int CW        = 32;              // Q16.16 coordinate
    localparam int DW        = CW + 1;          // coordinate difference
    localparam int SQ_W      = 2 * CW + 1;      // square of a difference
    localparam int SS_W      = SQ_W + 1;        // sum of two squares
    localparam int HALF_W    = SS_W / 2;        // split of a square sum for the multipliers
    localparam int PP_W      = HALF_W + 1 + DW; // partial product
    localparam int DH_W      = 2 * DW + 1;      // half determinant
    localparam int DET_W     = DH_W + 1;        // magnitude of the doubled determinant
    localparam int NUM_W     = PP_W + HALF_W + 1; // center numerator
    localparam int QB        = CW + 3;          // quotient bits kept by the divider
    localparam int D2_W      = DET_W + 1;       // divisor (twice the determinant)
    localparam int DIV_W     = D2_W + QB + 1;   // divider remainder
    localparam int VW        = QB + 2;          // unsaturated center sum
    localparam int RT_W      = CW + 1;          // square root bits
    localparam int REM_W     = 2 * RT_W + 2;    // square root remainder
    localparam int CFG_W     = 40;
    localparam int PAD_W     = 8;
    localparam int CFG_IDX_W = 2;

    // largest quotient that matters; anything above saturates the center anyway
    localparam logic [QB-1:0] CAP_Q = QB'(1) << (CW + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_SQ = 2'd0,
        CFG_DET     = 2'd1,
        CFG_PAD     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic signed [CW-1:0] x3;
        logic signed [CW-1:0] y3;
    } in_word_t;

    typedef struct packed {
        logic                 valid_res;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic [CW-1:0]        radius;
    } out_word_t;

    typedef struct packed {
        logic [CFG_W-1:0] edge_sq_threshold;
        logic [CFG_W-1:0] det_threshold;
        logic [PAD_W-1:0] radius_pad;
    } cfg_t;

    localparam cfg_t CFG_RESET = cfg_t'{CFG_W'(1), CFG_W'(1), PAD_W'(1)};

    // one divider lane: remainder, divisor, quotient so far
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [D2_W-1:0]  d2;
        logic [QB-1:0]    quo;
        logic             neg;
        logic             oflow;
    } div_lane_t;

    // front end to center divider
    typedef struct packed {
        in_word_t         pts;
        logic             bad;
        logic [DIV_W-1:0] nx_num;
        logic [DIV_W-1:0] ny_num;
        logic [D2_W-1:0]  d2;
        logic             neg_x;
        logic             neg_y;
    } front_t;

    // center divider to radius unit
    typedef struct packed {
        in_word_t             pts;
        logic                 bad;
        logic signed [CW-1:0] ctr_x;
        logic signed [CW-1:0] ctr_y;
    } ctr_t;

    // square root state
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RT_W-1:0]  root;
    } root_t;

    function automatic logic signed [DW-1:0] sdiff(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        return DW'(a) - DW'(b);
    endfunction

    function automatic logic [SQ_W-1:0] sq(input logic signed [DW-1:0] a);
        logic signed [2*DW-1:0] p;
        p = a * a;
        return p[SQ_W-1:0];
    endfunction

    function automatic logic signed [PP_W-1:0] pmul(input logic [HALF_W-1:0] u,
                                                    input logic signed [DW-1:0] s);
        logic signed [HALF_W:0] us;
        us = {1'b0, u};
        return us * s;
    endfunction

    function automatic logic signed [NUM_W-1:0] pjoin(input logic signed [PP_W-1:0] hi,
                                                      input logic signed [PP_W-1:0] lo);
        return (NUM_W'(hi) <<< HALF_W) + NUM_W'(lo);
    endfunction

    function automatic logic [NUM_W-1:0] nmag(input logic signed [NUM_W-1:0] v);
        return v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
    endfunction

    // set up a lane and flag quotients that cannot fit in QB bits
    function automatic div_lane_t div_init(input logic [DIV_W-1:0] num,
                                           input logic [D2_W-1:0] d2,
                                           input logic neg);
        div_lane_t l;
        l.rem   = num;
        l.d2    = d2;
        l.quo   = '0;
        l.neg   = neg;
        l.oflow = (num >= (DIV_W'(d2) << QB));
        return l;
    endfunction

    // one restoring division step for quotient bit sh
    function automatic div_lane_t div_step(input div_lane_t l, input int unsigned sh);
        logic [DIV_W-1:0] dsh;
        div_lane_t r;
        dsh = DIV_W'(l.d2) << sh;
        r   = l;
        if (l.rem >= dsh)
        begin
            r.rem = l.rem - dsh;
            r.quo = l.quo | (QB'(1) << sh);
        end
        return r;
    endfunction

    // rounded quotient applied to the base point, saturated to CW bits
    function automatic logic signed [CW-1:0] ctr_final(input logic signed [CW-1:0] base,
                                                       input div_lane_t l);
        logic [QB-1:0]        qv;
        logic signed [VW-1:0] v;
        qv = (l.oflow || (l.quo > CAP_Q)) ? CAP_Q : l.quo;
        v  = l.neg ? (VW'(base) - $signed({2'b00, qv})) : (VW'(base) + $signed({2'b00, qv}));
        if (v[VW-1:CW-1] == {(VW-CW+1){1'b0}} || v[VW-1:CW-1] == {(VW-CW+1){1'b1}})
            return v[CW-1:0];
        else if (v[VW-1])
            return {1'b1, {(CW-1){1'b0}}};
        else
            return {1'b0, {(CW-1){1'b1}}};
    endfunction

    // one digit of the integer square root, for root bit k
    function automatic root_t sqrt_step(input root_t s, input int unsigned k);
        logic [REM_W-1:0] t;
        root_t r;
        t = (REM_W'(s.root) << (k + 1)) | (REM_W'(1) << (2 * k));
        r = s;
        if (s.rem >= t)
        begin
            r.rem  = s.rem - t;
            r.root = s.root | (RT_W'(1) << k);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/trcc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module trcc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_vld,
    input  wire trcc_pkg::in_word_t in_data,
    input  wire trcc_pkg::cfg_t    cfg,
    output logic                   out_vld,
    output trcc_pkg::front_t       out_data
);
    import trcc_pkg::*;

    localparam int NST = 7;

    typedef struct packed {
        in_word_t             pts;
        logic signed [DW-1:0] bx, by, cx, cy, ex, ey;
    } f1_t;

    typedef struct packed {
        in_word_t               pts;
        logic signed [DW-1:0]   bx, by, cx, cy;
        logic [SQ_W-1:0]        bx2, by2, cx2, cy2, ex2, ey2;
        logic signed [2*DW-1:0] bxcy, bycx;
    } f2_t;

    typedef struct packed {
        in_word_t               pts;
        logic signed [DW-1:0]   bx, by, cx, cy;
        logic [SS_W-1:0]        sb, sc;
        logic                   edge_bad;
        logic signed [DH_W-1:0] dh;
    } f3_t;

    typedef struct packed {
        in_word_t               pts;
        logic                   bad;
        logic                   dneg;
        logic [DET_W-1:0]       dabs;
        logic signed [PP_W-1:0] xa_hi, xa_lo, xb_hi, xb_lo, ya_hi, ya_lo, yb_hi, yb_lo;
    } f4_t;

    typedef struct packed {
        in_word_t                pts;
        logic                    bad;
        logic                    dneg;
        logic [DET_W-1:0]        dabs;
        logic signed [NUM_W-1:0] xa, xb, ya, yb;
    } f5_t;

    typedef struct packed {
        in_word_t                pts;
        logic                    bad;
        logic                    dneg;
        logic [DET_W-1:0]        dabs;
        logic signed [NUM_W-1:0] nx, ny;
    } f6_t;

    logic [NST-1:0] vld_reg;
    f1_t    f1_reg, f1_next;
    f2_t    f2_reg, f2_next;
    f3_t    f3_reg, f3_next;
    f4_t    f4_reg, f4_next;
    f5_t    f5_reg, f5_next;
    f6_t    f6_reg, f6_next;
    front_t f7_reg, f7_next;
    logic [DH_W-1:0] abs_dh;

    // take differences against the first point, and from the second point to the third
    always_comb
    begin
        f1_next.pts = in_data;
        f1_next.bx  = sdiff(in_data.x2, in_data.x1);
        f1_next.by  = sdiff(in_data.y2, in_data.y1);
        f1_next.cx  = sdiff(in_data.x3, in_data.x1);
        f1_next.cy  = sdiff(in_data.y3, in_data.y1);
        f1_next.ex  = sdiff(in_data.x3, in_data.x2);
        f1_next.ey  = sdiff(in_data.y3, in_data.y2);
    end

    // squares and determinant products
    always_comb
    begin
        f2_next.pts  = f1_reg.pts;
        f2_next.bx   = f1_reg.bx;
        f2_next.by   = f1_reg.by;
        f2_next.cx   = f1_reg.cx;
        f2_next.cy   = f1_reg.cy;
        f2_next.bx2  = sq(f1_reg.bx);
        f2_next.by2  = sq(f1_reg.by);
        f2_next.cx2  = sq(f1_reg.cx);
        f2_next.cy2  = sq(f1_reg.cy);
        f2_next.ex2  = sq(f1_reg.ex);
        f2_next.ey2  = sq(f1_reg.ey);
        f2_next.bxcy = f1_reg.bx * f1_reg.cy;
        f2_next.bycx = f1_reg.by * f1_reg.cx;
    end

    // edge lengths, edge check and half determinant
    always_comb
    begin
        logic [SS_W-1:0] se;
        se               = SS_W'(f2_reg.ex2) + SS_W'(f2_reg.ey2);
        f3_next.pts      = f2_reg.pts;
        f3_next.bx       = f2_reg.bx;
        f3_next.by       = f2_reg.by;
        f3_next.cx       = f2_reg.cx;
        f3_next.cy       = f2_reg.cy;
        f3_next.sb       = SS_W'(f2_reg.bx2) + SS_W'(f2_reg.by2);
        f3_next.sc       = SS_W'(f2_reg.cx2) + SS_W'(f2_reg.cy2);
        f3_next.edge_bad = (se < SS_W'(cfg.edge_sq_threshold))
                        || (f3_next.sc < SS_W'(cfg.edge_sq_threshold))
                        || (f3_next.sb < SS_W'(cfg.edge_sq_threshold));
        f3_next.dh       = DH_W'(f2_reg.bxcy) - DH_W'(f2_reg.bycx);
    end

    // determinant check and numerator partial products
    assign abs_dh = f3_reg.dh[DH_W-1] ? DH_W'(-f3_reg.dh) : DH_W'(f3_reg.dh);

    always_comb
    begin
        f4_next.pts   = f3_reg.pts;
        f4_next.dneg  = f3_reg.dh[DH_W-1];
        f4_next.dabs  = {abs_dh, 1'b0};
        f4_next.bad   = f3_reg.edge_bad || (f4_next.dabs == '0)
                     || (f4_next.dabs < DET_W'(cfg.det_threshold));
        f4_next.xa_hi = pmul(f3_reg.sb[SS_W-1:HALF_W], f3_reg.cy);
        f4_next.xa_lo = pmul(f3_reg.sb[HALF_W-1:0], f3_reg.cy);
        f4_next.xb_hi = pmul(f3_reg.sc[SS_W-1:HALF_W], f3_reg.by);
        f4_next.xb_lo = pmul(f3_reg.sc[HALF_W-1:0], f3_reg.by);
        f4_next.ya_hi = pmul(f3_reg.sc[SS_W-1:HALF_W], f3_reg.bx);
        f4_next.ya_lo = pmul(f3_reg.sc[HALF_W-1:0], f3_reg.bx);
        f4_next.yb_hi = pmul(f3_reg.sb[SS_W-1:HALF_W], f3_reg.cx);
        f4_next.yb_lo = pmul(f3_reg.sb[HALF_W-1:0], f3_reg.cx);
    end

    // join partial products
    always_comb
    begin
        f5_next.pts  = f4_reg.pts;
        f5_next.bad  = f4_reg.bad;
        f5_next.dneg = f4_reg.dneg;
        f5_next.dabs = f4_reg.dabs;
        f5_next.xa   = pjoin(f4_reg.xa_hi, f4_reg.xa_lo);
        f5_next.xb   = pjoin(f4_reg.xb_hi, f4_reg.xb_lo);
        f5_next.ya   = pjoin(f4_reg.ya_hi, f4_reg.ya_lo);
        f5_next.yb   = pjoin(f4_reg.yb_hi, f4_reg.yb_lo);
    end

    // center numerators
    always_comb
    begin
        f6_next.pts  = f5_reg.pts;
        f6_next.bad  = f5_reg.bad;
        f6_next.dneg = f5_reg.dneg;
        f6_next.dabs = f5_reg.dabs;
        f6_next.nx   = f5_reg.xa - f5_reg.xb;
        f6_next.ny   = f5_reg.ya - f5_reg.yb;
    end

    // rounding numerators 2|n| + |d| over divisor 2|d|
    always_comb
    begin
        f7_next.pts    = f6_reg.pts;
        f7_next.bad    = f6_reg.bad;
        f7_next.nx_num = (DIV_W'(nmag(f6_reg.nx)) << 1) + DIV_W'(f6_reg.dabs);
        f7_next.ny_num = (DIV_W'(nmag(f6_reg.ny)) << 1) + DIV_W'(f6_reg.dabs);
        f7_next.d2     = {f6_reg.dabs, 1'b0};
        f7_next.neg_x  = f6_reg.nx[NUM_W-1] ^ f6_reg.dneg;
        f7_next.neg_y  = f6_reg.ny[NUM_W-1] ^ f6_reg.dneg;
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            f4_reg <= f4_next;
            f5_reg <= f5_next;
            f6_reg <= f6_next;
            f7_reg <= f7_next;
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_data = f7_reg;

endmodule

`default_nettype wire

FILE: rtl/trcc_center.sv
`timescale 1ns / 1ps
`default_nettype none

module trcc_center (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            in_vld,
    input  wire trcc_pkg::front_t in_data,
    output logic                 out_vld,
    output trcc_pkg::ctr_t       out_data
);
    import trcc_pkg::*;

    typedef struct packed {
        in_word_t  pts;
        logic      bad;
        div_lane_t lx;
        div_lane_t ly;
    } cs_t;

    logic [QB:0] vld_reg;
    cs_t  st_reg  [QB+1];
    cs_t  st_next [QB+1];
    logic out_vld_reg;
    ctr_t out_reg, out_next;

    // overflow precheck and lane setup
    always_comb
    begin
        st_next[0].pts = in_data.pts;
        st_next[0].bad = in_data.bad;
        st_next[0].lx  = div_init(in_data.nx_num, in_data.d2, in_data.neg_x);
        st_next[0].ly  = div_init(in_data.ny_num, in_data.d2, in_data.neg_y);
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        always_comb
        begin
            st_next[j].pts = st_reg[j-1].pts;
            st_next[j].bad = st_reg[j-1].bad;
            st_next[j].lx  = div_step(st_reg[j-1].lx, QB - j);
            st_next[j].ly  = div_step(st_reg[j-1].ly, QB - j);
        end
    end

    // clamp quotient and add the first point
    always_comb
    begin
        out_next.pts   = st_reg[QB].pts;
        out_next.bad   = st_reg[QB].bad;
        out_next.ctr_x = ctr_final(st_reg[QB].pts.x1, st_reg[QB].lx);
        out_next.ctr_y = ctr_final(st_reg[QB].pts.y1, st_reg[QB].ly);
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[QB-1:0], in_vld};
            out_vld_reg <= vld_reg[QB];
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j <= QB; j++)
            begin
                st_reg[j] <= st_next[j];
            end
            out_reg <= out_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_reg;

endmodule

`default_nettype wire

FILE: rtl/trcc_radius.sv
`timescale 1ns / 1ps
`default_nettype none

module trcc_radius (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_vld,
    input  wire trcc_pkg::ctr_t        in_data,
    input  wire logic [trcc_pkg::PAD_W-1:0] pad,
    output logic                       out_vld,
    output trcc_pkg::out_word_t        out_data
);
    import trcc_pkg::*;

    localparam int NST = RT_W + 4;

    typedef struct packed {
        logic                 bad;
        logic signed [CW-1:0] cx, cy;
        logic signed [DW-1:0] dx1, dy1, dx2, dy2, dx3, dy3;
    } r1_t;

    typedef struct packed {
        logic                 bad;
        logic signed [CW-1:0] cx, cy;
        logic [SQ_W-1:0]      qx1, qy1, qx2, qy2, qx3, qy3;
    } r2_t;

    typedef struct packed {
        logic                 bad;
        logic signed [CW-1:0] cx, cy;
        logic [SS_W-1:0]      s1, s2, s3;
    } r3_t;

    typedef struct packed {
        logic                 bad;
        logic signed [CW-1:0] cx, cy;
        root_t                st;
    } rt_t;

    logic [NST-1:0] vld_reg;
    r1_t  r1_reg, r1_next;
    r2_t  r2_reg, r2_next;
    r3_t  r3_reg, r3_next;
    rt_t  rt_reg  [RT_W+1];
    rt_t  rt_next [RT_W+1];
    logic      out_vld_reg;
    out_word_t out_reg, out_next;

    // distances from the saturated center
    always_comb
    begin
        r1_next.bad = in_data.bad;
        r1_next.cx  = in_data.ctr_x;
        r1_next.cy  = in_data.ctr_y;
        r1_next.dx1 = sdiff(in_data.pts.x1, in_data.ctr_x);
        r1_next.dy1 = sdiff(in_data.pts.y1, in_data.ctr_y);
        r1_next.dx2 = sdiff(in_data.pts.x2, in_data.ctr_x);
        r1_next.dy2 = sdiff(in_data.pts.y2, in_data.ctr_y);
        r1_next.dx3 = sdiff(in_data.pts.x3, in_data.ctr_x);
        r1_next.dy3 = sdiff(in_data.pts.y3, in_data.ctr_y);
    end

    // squares
    always_comb
    begin
        r2_next.bad = r1_reg.bad;
        r2_next.cx  = r1_reg.cx;
        r2_next.cy  = r1_reg.cy;
        r2_next.qx1 = sq(r1_reg.dx1);
        r2_next.qy1 = sq(r1_reg.dy1);
        r2_next.qx2 = sq(r1_reg.dx2);
        r2_next.qy2 = sq(r1_reg.dy2);
        r2_next.qx3 = sq(r1_reg.dx3);
        r2_next.qy3 = sq(r1_reg.dy3);
    end

    // squared distances
    always_comb
    begin
        r3_next.bad = r2_reg.bad;
        r3_next.cx  = r2_reg.cx;
        r3_next.cy  = r2_reg.cy;
        r3_next.s1  = SS_W'(r2_reg.qx1) + SS_W'(r2_reg.qy1);
        r3_next.s2  = SS_W'(r2_reg.qx2) + SS_W'(r2_reg.qy2);
        r3_next.s3  = SS_W'(r2_reg.qx3) + SS_W'(r2_reg.qy3);
    end

    // pick the largest and seed the square root
    always_comb
    begin
        logic [SS_W-1:0] best;
        best = r3_reg.s1;
        if (r3_reg.s2 > best)
            best = r3_reg.s2;
        if (r3_reg.s3 > best)
            best = r3_reg.s3;
        rt_next[0].bad     = r3_reg.bad;
        rt_next[0].cx      = r3_reg.cx;
        rt_next[0].cy      = r3_reg.cy;
        rt_next[0].st.rem  = REM_W'(best);
        rt_next[0].st.root = '0;
    end

    // one root bit per stage, most significant first
    for (genvar j = 1; j <= RT_W; j++)
    begin : g_root
        always_comb
        begin
            rt_next[j].bad = rt_reg[j-1].bad;
            rt_next[j].cx  = rt_reg[j-1].cx;
            rt_next[j].cy  = rt_reg[j-1].cy;
            rt_next[j].st  = sqrt_step(rt_reg[j-1].st, RT_W - j);
        end
    end

    // saturate, add the pad, zero a rejected triangle
    always_comb
    begin
        logic [CW-1:0] r_sat;
        logic [CW:0]   r_sum;
        r_sat = rt_reg[RT_W].st.root[RT_W-1] ? {CW{1'b1}} : rt_reg[RT_W].st.root[CW-1:0];
        r_sum = {1'b0, r_sat} + (CW + 1)'(pad);
        if (rt_reg[RT_W].bad)
        begin
            out_next = '0;
        end
        else
        begin
            out_next.valid_res = 1'b1;
            out_next.center_x  = rt_reg[RT_W].cx;
            out_next.center_y  = rt_reg[RT_W].cy;
            out_next.radius    = r_sum[CW] ? {CW{1'b1}} : r_sum[CW-1:0];
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NST-2:0], in_vld};
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            r3_reg <= r3_next;
            for (int j = 0; j <= RT_W; j++)
            begin
                rt_reg[j] <= rt_next[j];
            end
            out_reg <= out_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_reg;

endmodule

`default_nettype wire

FILE: rtl/triangle_circumcircle.sv
// Triangle circumcircle: three signed Q16.16 points in, center and radius out.
// Input channel: in_valid / in_stall carry in_word (x1, y1 .. x3, y3). A word
// is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry out_word (valid_res, center_x,
// center_y, radius), one result word for every input word, in order.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx (0 edge squared
// threshold, 1 determinant threshold, 2 radius pad); write only while idle.
// The datapath holds 82 register stages. Throughput: one word per cycle unless
// a stalled output holds the pipeline; the datapath is fully pipelined: 7 front
// stages, a 35-stage restoring divider per center axis, and a 33-stage square root.
// A stalled output holds its word; while it is held the whole pipeline
// freezes and in_stall is raised in the same cycle, so nothing is lost.
// Reset clears every valid bit and loads the register defaults (each set to 1).
`timescale 1ns / 1ps
`default_nettype none

module triangle_circumcircle (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire trcc_pkg::in_word_t            in_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output trcc_pkg::out_word_t                out_word,
    input  wire logic                          cfg_we,
    input  wire logic [trcc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [trcc_pkg::CFG_W-1:0]    cfg_wdata
);
    import trcc_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   adv;
    logic   front_vld, ctr_vld;
    front_t front_data;
    ctr_t   ctr_data;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_EDGE_SQ: cfg_next.edge_sq_threshold = cfg_wdata;
                CFG_DET:     cfg_next.det_threshold     = cfg_wdata;
                CFG_PAD:     cfg_next.radius_pad        = cfg_wdata[PAD_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // freeze the pipeline only while a finished word waits
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    trcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (in_valid),
        .in_data  (in_word),
        .cfg      (cfg_reg),
        .out_vld  (front_vld),
        .out_data (front_data)
    );

    trcc_center u_center (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (front_vld),
        .in_data  (front_data),
        .out_vld  (ctr_vld),
        .out_data (ctr_data)
    );

    trcc_radius u_radius (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (ctr_vld),
        .in_data  (ctr_data),
        .pad      (cfg_reg.radius_pad),
        .out_vld  (out_valid),
        .out_data (out_word)
    );

endmodule

`default_nettype wire

FILE: rtl/trcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module trcc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire trcc_pkg::out_word_t out_word
);
    import trcc_pkg::*;

    // a stalled word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // a stalled word does not change
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_word))
        else $error("output word changed while stalled");

    // input backpressure comes only from a held output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output backpressure");

    // a rejected triangle reports all zero
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.valid_res |->
            (out_word.center_x == '0) && (out_word.center_y == '0)
            && (out_word.radius == '0))
        else $error("rejected triangle with nonzero circle");

endmodule

bind triangle_circumcircle trcc_checker u_trcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

`default_nettype wire

FILE: dv/triangle_circumcircle_tb.sv
`timescale 1ns / 1ps

module triangle_circumcircle_tb;
    import trcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;
    logic      cfg_we;
    cfg_idx_t  cfg_idx;
    logic [CFG_W-1:0] cfg_wdata;

    triangle_circumcircle u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the registers
    logic [CFG_W-1:0] edge_thr;
    logic [CFG_W-1:0] det_thr;
    logic [PAD_W-1:0] pad;

    out_word_t circle_q[$];
    int        errors;
    int        words_in;
    int        words_out;
    int        circles_out;
    int        idle_cycles;
    bit        no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // squared length of a difference vector
    function automatic logic signed [127:0] len_sq(input logic signed [127:0] dx,
                                                   input logic signed [127:0] dy);
        return dx * dx + dy * dy;
    endfunction

    // rounded center component applied to the base, saturated to CW bits
    function automatic logic signed [127:0] center_axis(input logic signed [127:0] base,
                                                        input logic signed [127:0] num,
                                                        input logic signed [127:0] d);
        logic signed [127:0] nm;
        logic signed [127:0] dm;
        logic signed [127:0] q;
        logic signed [127:0] v;
        logic signed [127:0] cap;
        nm  = (num < 0) ? -num : num;
        dm  = (d < 0) ? -d : d;
        cap = 128'sd1 <<< (CW + 1);
        q   = (2 * nm + dm) / (2 * dm);
        if (q > cap)
            q = cap;
        v = ((num < 0) != (d < 0)) ? base - q : base + q;
        if (v > (128'sd1 <<< (CW - 1)) - 1)
            v = (128'sd1 <<< (CW - 1)) - 1;
        if (v < -(128'sd1 <<< (CW - 1)))
            v = -(128'sd1 <<< (CW - 1));
        return v;
    endfunction

    // floor square root, the argument stays below 2^80
    function automatic logic signed [127:0] root_floor(input logic signed [127:0] n);
        logic signed [127:0] res;
        logic signed [127:0] t;
        res = 0;
        for (int k = 40; k >= 0; k--)
        begin
            t = res | (128'sd1 <<< k);
            if (t * t <= n)
                res = t;
        end
        return res;
    endfunction

    // expected circumcircle of one word
    function automatic out_word_t circle_predict(input in_word_t w);
        logic signed [127:0] x1, y1, x2, y2, x3, y3;
        logic signed [127:0] bx, by, cx, cy, d, dm, sb, sc, nx, ny, ux, uy;
        logic signed [127:0] best, s, r, et, lim;
        out_word_t o;
        o  = '0;
        x1 = $signed(w.x1); y1 = $signed(w.y1);
        x2 = $signed(w.x2); y2 = $signed(w.y2);
        x3 = $signed(w.x3); y3 = $signed(w.y3);
        et = $signed({88'b0, edge_thr});
        if (len_sq(x3 - x2, y3 - y2) < et || len_sq(x1 - x3, y1 - y3) < et ||
            len_sq(x2 - x1, y2 - y1) < et)
            return o;
        bx = x2 - x1; by = y2 - y1;
        cx = x3 - x1; cy = y3 - y1;
        d  = 2 * (bx * cy - by * cx);
        dm = (d < 0) ? -d : d;
        // zero determinant is rejected whatever the threshold
        if (dm == 0 || dm < $signed({88'b0, det_thr}))
            return o;
        sb = len_sq(bx, by);
        sc = len_sq(cx, cy);
        nx = sb * cy - sc * by;
        ny = sc * bx - sb * cx;
        ux = center_axis(x1, nx, d);
        uy = center_axis(y1, ny, d);
        best = len_sq(x1 - ux, y1 - uy);
        s = len_sq(x2 - ux, y2 - uy);
        if (s > best)
            best = s;
        s = len_sq(x3 - ux, y3 - uy);
        if (s > best)
            best = s;
        lim = (128'sd1 <<< CW) - 1;
        r = root_floor(best);
        if (r > lim)
            r = lim;
        r = r + pad;
        if (r > lim)
            r = lim;
        o.valid_res = 1'b1;
        o.center_x  = ux[CW-1:0];
        o.center_y  = uy[CW-1:0];
        o.radius    = r[CW-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [CW-1:0] got,
                                   input logic [CW-1:0] want);
        $display("MISMATCH result %0d %s: got %h want %h", words_out, field, got, want);
        errors++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_EDGE_SQ: edge_thr = val;
            CFG_DET:     det_thr  = val;
            default:     pad      = val[PAD_W-1:0];
        endcase
        @(negedge clk);
    endtask

    // let every expected circle drain, then let the pipeline empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (circle_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // present one word at the falling edge and hold it until taken
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        int gap;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        circle_q.push_back(typed ? want : circle_predict(w));
        words_in++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic [CW-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // random triangle: mostly small ones, some wide, degenerate or extreme
    function automatic in_word_t random_tri();
        in_word_t w;
        logic [CW-1:0] bx, by, dx, dy;
        int spread;
        int mode;
        mode = $urandom_range(0, 9);
        bx = $urandom;
        by = $urandom;
        spread = $urandom_range(1, 31);
        case (mode)
            0, 1:
                w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            7:
            begin
                dx = $signed($urandom) >>> (CW - spread);
                dy = $signed($urandom) >>> (CW - spread);
                w = {bx, by, bx + dx, by + dy, bx + 2 * dx, by + 2 * dy};
            end
            8:
            begin
                w = {bx, by, bx, by, bx + ($signed($urandom) >>> (CW - spread)),
                     by + ($signed($urandom) >>> (CW - spread))};
            end
            9:
                w = {pick_extreme(), pick_extreme(), pick_extreme(),
                     pick_extreme(), pick_extreme(), pick_extreme()};
            default:
            begin
                w.x1 = bx + ($signed($urandom) >>> (CW - spread));
                w.y1 = by + ($signed($urandom) >>> (CW - spread));
                w.x2 = bx + ($signed($urandom) >>> (CW - spread));
                w.y2 = by + ($signed($urandom) >>> (CW - spread));
                w.x3 = bx + ($signed($urandom) >>> (CW - spread));
                w.y3 = by + ($signed($urandom) >>> (CW - spread));
            end
        endcase
        return w;
    endfunction

    // directed stimulus
    typedef struct {
        in_word_t  pts;
        bit        typed;
        out_word_t want;
    } tri_row_t;

    localparam out_word_t NO_CIRCLE = '0;
    localparam logic [CW-1:0] MX = 32'h7fff_ffff;
    localparam logic [CW-1:0] MN = 32'h8000_0000;

    tri_row_t tri_rows[] = '{
        '{'{0, 0, 0, 0, 0, 0}, 1, NO_CIRCLE},                       // all points equal
        '{'{0, 0, 1, 0, 2, 0}, 1, NO_CIRCLE},                       // collinear, unit steps
        '{'{5, 5, 5, 5, 90, 7}, 1, NO_CIRCLE},                      // repeated point
        '{'{0, 0, 32'h10000, 0, 0, 32'h10000}, 0, NO_CIRCLE},       // right triangle
        '{'{0, 0, 1, 0, 0, 1}, 0, NO_CIRCLE},                       // smallest triangle
        '{'{0, 0, 3, 0, 0, 1}, 0, NO_CIRCLE},                       // rounding tie
        '{'{MN, MN, MX, MN, MN, MX}, 0, NO_CIRCLE},                 // full range corners
        '{'{MX, MX, MN, MX, MX, MN}, 0, NO_CIRCLE},
        '{'{MN, 0, MX, 0, 0, MX}, 0, NO_CIRCLE},
        '{'{MN, MN, MX, MX, MN, MX}, 0, NO_CIRCLE},
        '{'{0, 0, 32'h1000_0000, 1, 32'h2000_0000, 3}, 0, NO_CIRCLE}, // center saturates
        '{'{MX, MX, MX - 1, MX, MX, MX - 1}, 0, NO_CIRCLE},         // near upper corner
        '{'{MN, MN, MN + 1, MN, MN, MN + 1}, 0, NO_CIRCLE},         // near lower corner
        '{'{32'hffff_0000, 32'h0001_0000, 32'h0002_8000, 32'hfffe_0000,
            32'h0000_4000, 32'h0003_c000}, 0, NO_CIRCLE}
    };

    // result side: random stall bursts, then check at the rising edge
    initial
    begin
        int stall_left;
        int r;
        out_word_t want;
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (circle_q.size() == 0)
                begin
                    report_mismatch("unexpected word", out_word.center_x, '0);
                end
                else
                begin
                    want = circle_q.pop_front();
                    if (out_word.valid_res !== want.valid_res)
                        report_mismatch("valid_res", CW'(out_word.valid_res),
                                        CW'(want.valid_res));
                    if (out_word.center_x !== want.center_x)
                        report_mismatch("center_x", out_word.center_x, want.center_x);
                    if (out_word.center_y !== want.center_y)
                        report_mismatch("center_y", out_word.center_y, want.center_y);
                    if (out_word.radius !== want.radius)
                        report_mismatch("radius", out_word.radius, want.radius);
                    if (want.valid_res)
                        circles_out++;
                end
                words_out++;
            end
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (!no_idle)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    stall_left = 0;
                else if (r < 95)
                    stall_left = $urandom_range(1, 4);
                else
                    stall_left = $urandom_range(15, 60);
            end
            out_stall <= (stall_left > 0);
        end
    end

    // watchdog: cycles with no word moving on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [CFG_W-1:0] phase_edge[5];
        logic [CFG_W-1:0] phase_det[5];
        logic [PAD_W-1:0] phase_pad[5];
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_EDGE_SQ;
        cfg_wdata = '0;
        errors    = 0;
        words_in  = 0;
        words_out = 0;
        circles_out = 0;
        no_idle   = 1'b0;
        edge_thr  = CFG_RESET.edge_sq_threshold;
        det_thr   = CFG_RESET.det_threshold;
        pad       = CFG_RESET.radius_pad;
        rst_n     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows at the reset settings
        foreach (tri_rows[i])
            send_word(tri_rows[i].pts, tri_rows[i].typed, tri_rows[i].want);
        wait_drained();

        phase_edge = '{0, CFG_MAX, 40'h1_0000_0000, 40'h0_0000_0400, 0};
        phase_det  = '{0, CFG_MAX, 40'h0_0010_0000, 40'h0_0000_0010, 0};
        phase_pad  = '{0, 8'hff, 8'h08, 8'h01, 0};
        phase_edge[4] = CFG_W'({$urandom, $urandom}) & CFG_MAX;
        phase_det[4]  = CFG_W'({$urandom, $urandom}) & CFG_MAX;
        phase_pad[4]  = PAD_W'($urandom_range(0, 255));

        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_EDGE_SQ, phase_edge[p]);
            write_reg(CFG_DET, phase_det[p]);
            write_reg(CFG_PAD, {32'b0, phase_pad[p]});
            for (int n = 0; n < 300; n++)
            begin
                // a stretch with no idling on either side
                no_idle = (n >= 100 && n < 160);
                // hold off once until the pipeline has drained
                if (p == 2 && n == 150)
                begin
                    in_valid <= 1'b0;
                    while (circle_q.size() != 0)
                        @(negedge clk);
                end
                send_word(random_tri(), 1'b0, NO_CIRCLE);
            end
            no_idle = 1'b0;
            wait_drained();
        end

        $display("covered %0d words, %0d circles, %0d rejected, across 6 settings",
                 words_in, circles_out, words_out - circles_out);
        if (errors == 0 && circle_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: triangle_circumcircle.f
rtl/trcc_pkg.sv
rtl/trcc_front.sv
rtl/trcc_center.sv
rtl/trcc_radius.sv
rtl/triangle_circumcircle.sv
rtl/trcc_checker.sv
dv/triangle_circumcircle_tb.sv
